// File: hw/rtl/roberts_cross_gradient_macros.svh
// ----------------------------------------------------------------------------
// Roberts cross gradient assertion macros
// Shared concurrent assertion forms for the gradient block.
// ----------------------------------------------------------------------------
`ifndef ROBERTS_CROSS_GRADIENT_MACROS_SVH
`define ROBERTS_CROSS_GRADIENT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RCG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcg assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RCG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcg assertion failed");

`endif

// File: hw/rtl/rcg_pkg.sv
// ----------------------------------------------------------------------------
// rcg_pkg
// Widths, register indexes and the pipeline item type of the gradient block.
// ----------------------------------------------------------------------------
package rcg_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int PIXEL_BITS = 16;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int WCNT_W     = ADDR_W + 1;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 12;
    localparam int GRAD_W     = PIXEL_BITS + 1;
    localparam int CFG_DATA_W = 16;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_DIRECTION = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    // One accepted pixel on its way from the counters to the subtractor.
    typedef struct packed {
        logic                  produce;
        logic                  dir;
        logic [PIXEL_BITS-1:0] prev;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic                  last;
    } item_t;

endpackage

// File: hw/rtl/rcg_row_mem.sv
// ----------------------------------------------------------------------------
// rcg_row_mem
// Line store of the row above: one synchronous port, read before write.
// ----------------------------------------------------------------------------
module rcg_row_mem
    import rcg_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [PIXEL_BITS-1:0] wdata,
    output logic [PIXEL_BITS-1:0] rdata
);

    logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rdata_reg;

    // Old contents come out; the arriving pixel takes its place.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/rcg_front.sv
// ----------------------------------------------------------------------------
// rcg_front
// Configuration registers, raster counters and the first pipeline stage.
// ----------------------------------------------------------------------------
module rcg_front
    import rcg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic [PIXEL_BITS-1:0] pixel_value,
    input  logic                  s1_take,
    output logic                  s1_valid,
    output item_t                 s1_item,
    output logic [ADDR_W-1:0]     mem_addr
);

    logic                  dir_reg;
    logic [WCNT_W-1:0]     width_reg;
    logic [ROW_W-1:0]      height_reg;
    logic [ADDR_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [PIXEL_BITS-1:0] prev_reg;
    logic                  s1_valid_reg, s1_valid_next;
    item_t                 s1_item_reg;

    logic [WCNT_W-1:0]     col_ext, col_inc, width_wr;
    logic [ROW_W:0]        row_inc;
    logic [ROW_W-1:0]      height_wr;
    logic                  row_end, interior, last;

    // Clamp sizes once, at write time.
    always_comb
    begin
        width_wr = cfg_data[WCNT_W-1:0];
        if (width_wr < WCNT_W'(3))
            width_wr = WCNT_W'(3);
        else if (width_wr > WCNT_W'(MAX_WIDTH))
            width_wr = WCNT_W'(MAX_WIDTH);
        height_wr = cfg_data[ROW_W-1:0];
        if (height_wr < ROW_W'(3))
            height_wr = ROW_W'(3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg    <= 1'b0;
            width_reg  <= WCNT_W'(MAX_WIDTH);
            height_reg <= ROW_W'(4096);
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_DIRECTION: dir_reg    <= cfg_data[0];
                REG_WIDTH:     width_reg  <= width_wr;
                REG_HEIGHT:    height_reg <= height_wr;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        col_ext  = {1'b0, col_reg};
        col_inc  = col_ext + WCNT_W'(1);
        row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);
        row_end  = (col_inc >= width_reg);
        interior = (row_reg >= ROW_W'(2)) && (row_reg < height_reg)
                && (col_reg >= ADDR_W'(2)) && (col_ext < width_reg);
        last     = (row_inc >= {1'b0, height_reg}) && row_end;

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = (row_inc >= {1'b0, height_reg}) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[ADDR_W-1:0];
            end
        end

        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_take)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            prev_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            if (accept)
                prev_reg <= pixel_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.produce <= interior;
            s1_item_reg.dir     <= dir_reg;
            s1_item_reg.prev    <= prev_reg;
            s1_item_reg.row     <= row_reg - ROW_W'(1);
            s1_item_reg.col     <= COL_W'(col_reg - ADDR_W'(1));
            s1_item_reg.last    <= last;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;
    assign mem_addr = col_reg;

endmodule

// File: hw/rtl/rcg_diff.sv
// ----------------------------------------------------------------------------
// rcg_diff
// Upper-row window, diagonal difference and the output register.
// ----------------------------------------------------------------------------
module rcg_diff
    import rcg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s1_valid,
    input  item_t                    s1_item,
    input  logic [PIXEL_BITS-1:0]    rd_data,
    input  logic                     out_ready,
    output logic                     s1_take,
    output logic                     out_valid,
    output logic signed [GRAD_W-1:0] gradient,
    output logic [ROW_W-1:0]         out_row,
    output logic [COL_W-1:0]         out_col,
    output logic                     last_of_image
);

    logic [PIXEL_BITS-1:0]    win1_reg, win2_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [GRAD_W-1:0] grad_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [COL_W-1:0]         col_reg;
    logic                     last_reg;
    logic [PIXEL_BITS-1:0]    sub;
    logic [GRAD_W-1:0]        diff;

    // An item with no result never waits on the output side.
    assign s1_take = s1_valid && (!s1_item.produce || !out_valid_reg || out_ready);

    always_comb
    begin
        sub  = s1_item.dir ? rd_data : win2_reg;
        diff = {1'b0, s1_item.prev} - {1'b0, sub};
        if (s1_take && s1_item.produce)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win1_reg      <= '0;
            win2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_take)
            begin
                win1_reg <= rd_data;
                win2_reg <= win1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && s1_item.produce)
        begin
            grad_reg <= signed'(diff);
            row_reg  <= s1_item.row;
            col_reg  <= s1_item.col;
            last_reg <= s1_item.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign gradient      = grad_reg;
    assign out_row       = row_reg;
    assign out_col       = col_reg;
    assign last_of_image = last_reg;

endmodule

// File: hw/rtl/roberts_cross_gradient.sv
// ----------------------------------------------------------------------------
// roberts_cross_gradient
// Roberts cross diagonal gradient over a raster pixel stream.
// ----------------------------------------------------------------------------
//
//   channel   signals                                         direction
//   -------   ---------------------------------------------   ---------
//   cfg       cfg_valid/cfg_ready, cfg_index, cfg_data         in
//   in        in_valid/in_ready, pixel_value                   in
//   out       out_valid/out_ready, gradient, out_row, out_col,  out
//             last_of_image
//
// One pixel transaction per cycle sustained while out_ready stays high; the row
// store is a single read-before-write port, so read and write of a column
// share one cycle. Accepting a pixel loads stage one and the line store read
// register; taking stage one registers the difference in the output register.
// Reset clears counters, window and valid flags and sets both sizes to 4096;
// the row store is not cleared and needs no clearing pass, since interior reads
// hit written entries. A stalled result holds an interior item in stage one;
// border pixels keep flowing past it.
// ----------------------------------------------------------------------------
module roberts_cross_gradient
    import rcg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [REG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [PIXEL_BITS-1:0]    pixel_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [GRAD_W-1:0] gradient,
    output logic [ROW_W-1:0]         out_row,
    output logic [COL_W-1:0]         out_col,
    output logic                     last_of_image
);

`include "roberts_cross_gradient_macros.svh"

    logic                  accept;
    logic                  s1_valid;
    logic                  s1_take;
    item_t                 s1_item;
    logic [ADDR_W-1:0]     mem_addr;
    logic [PIXEL_BITS-1:0] rd_data;

    // Configuration writes always land at once.
    assign cfg_ready = 1'b1;

    // Take a new pixel whenever stage one is empty or draining this cycle.
    assign in_ready = !s1_valid || s1_take;
    assign accept   = in_valid && in_ready;

    rcg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .pixel_value (pixel_value),
        .s1_take     (s1_take),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .mem_addr    (mem_addr)
    );

    // Read the row above at the arriving column and overwrite it.
    rcg_row_mem u_row_mem (
        .clk   (clk),
        .en    (accept),
        .addr  (mem_addr),
        .wdata (pixel_value),
        .rdata (rd_data)
    );

    rcg_diff u_diff (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1_item       (s1_item),
        .rd_data       (rd_data),
        .out_ready     (out_ready),
        .s1_take       (s1_take),
        .out_valid     (out_valid),
        .gradient      (gradient),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_image (last_of_image)
    );

    // An accepted pixel always occupies stage one on the next cycle.
    `RCG_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid)
    // Never overwrite a result that is still waiting.
    `RCG_ASSERT_IMP(a_no_overwrite, out_valid && !out_ready && s1_valid && s1_item.produce,
        !s1_take)
    // Results only come from interior positions.
    `RCG_ASSERT_IMP(a_interior_only, out_valid, out_row != '0 && out_col != '0)

endmodule

// File: verif/gradient_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient checker
// Watches the register, pixel and result channels of the Roberts cross block,
// predicts every gradient from the accepted pixels and compares results.
// ----------------------------------------------------------------------------
module gradient_checker
    import rcg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [REG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [PIXEL_BITS-1:0]    pixel_value,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [GRAD_W-1:0] gradient,
    input  logic [ROW_W-1:0]         out_row,
    input  logic [COL_W-1:0]         out_col,
    input  logic                     last_of_image,
    output int                       mismatch_count,
    output int                       pending_count,
    output int                       gradients_checked,
    output int                       pixels_seen,
    output int                       reg_writes
);

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic                     last;
    } gradient_result_t;

    logic [PIXEL_BITS-1:0] line_buf [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] left_pix;
    logic [PIXEL_BITS-1:0] diag_win [3];
    logic                  dir_vertical;
    logic [WCNT_W-1:0]     width_reg;
    logic [ROW_W-1:0]      height_reg;
    int                    row_pos;
    int                    col_pos;
    gradient_result_t      pending_gradients [$];
    int                    errs;
    int                    checked;
    int                    pixels;
    int                    writes;

    function automatic int eff_width();
        int w;
        w = int'(width_reg);
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(height_reg);
        if (h < 3) h = 3;
        return h;
    endfunction

    // Shift the upper window, emit the gradient of the interior pixel that
    // this pixel completes, then store the pixel and advance the raster.
    task automatic advance_raster(input logic [PIXEL_BITS-1:0] pix);
        int                    w;
        int                    h;
        int                    c;
        int                    r;
        logic [PIXEL_BITS-1:0] sub;
        gradient_result_t      want;
        w = eff_width();
        h = eff_height();
        c = col_pos;
        r = row_pos;
        diag_win[2] = diag_win[1];
        diag_win[1] = diag_win[0];
        diag_win[0] = line_buf[c];
        if (r >= 2 && r < h && c >= 2 && c < w)
        begin
            sub       = dir_vertical ? diag_win[0] : diag_win[2];
            want.grad = $signed({1'b0, left_pix}) - $signed({1'b0, sub});
            want.row  = ROW_W'(r - 1);
            want.col  = COL_W'(c - 1);
            want.last = (r + 1 >= h) && (c + 1 >= w);
            pending_gradients.push_back(want);
        end
        line_buf[c] = pix;
        left_pix    = pix;
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
        pixels++;
    endtask

    task automatic check_result();
        gradient_result_t want;
        if (pending_gradients.size() == 0)
        begin
            errs++;
            if (errs <= 10)
                $display("unexpected result: grad %0d row %0d col %0d last %0b",
                         gradient, out_row, out_col, last_of_image);
        end
        else
        begin
            want = pending_gradients.pop_front();
            checked++;
            if (gradient !== want.grad || out_row !== want.row ||
                out_col !== want.col || last_of_image !== want.last)
            begin
                errs++;
                if (errs <= 10)
                begin
                    $display("mismatch: expected grad %0d row %0d col %0d last %0b",
                             $signed(want.grad), want.row, want.col, want.last);
                    $display("          got      grad %0d row %0d col %0d last %0b",
                             gradient, out_row, out_col, last_of_image);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_gradients.delete();
            left_pix          = '0;
            diag_win[0]       = '0;
            diag_win[1]       = '0;
            diag_win[2]       = '0;
            dir_vertical      = 1'b0;
            width_reg         = WCNT_W'(MAX_WIDTH);
            height_reg        = ROW_W'(4096);
            row_pos           = 0;
            col_pos           = 0;
            errs              = 0;
            checked           = 0;
            pixels            = 0;
            writes            = 0;
            mismatch_count    <= 0;
            pending_count     <= 0;
            gradients_checked <= 0;
            pixels_seen       <= 0;
            reg_writes        <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_valid && cfg_ready)
            begin
                writes++;
                case (cfg_index)
                    REG_DIRECTION: dir_vertical = cfg_data[0];
                    REG_WIDTH:     width_reg    = cfg_data[WCNT_W-1:0];
                    REG_HEIGHT:    height_reg   = cfg_data[ROW_W-1:0];
                    default:       ;
                endcase
            end
            if (in_valid && in_ready)
                advance_raster(pixel_value);
            mismatch_count    <= errs;
            pending_count     <= pending_gradients.size();
            gradients_checked <= checked;
            pixels_seen       <= pixels;
            reg_writes        <= writes;
        end
    end

endmodule

// File: verif/roberts_cross_gradient_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roberts cross gradient testbench
// Streams raster images through the block under a range of sizes and both
// diagonal masks, with random idling on both channels, and leaves all
// prediction and comparison to the gradient checker beside the block.
// ----------------------------------------------------------------------------
module roberts_cross_gradient_tb;
    import rcg_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 6;
    // Drain time after the two pipeline stages, before touching registers.
    localparam int PIPE_DRAIN       = 8;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_PIXELS    = 1500;
    localparam int QUIET_PIXELS     = 200;
    localparam int WIDE_PIXELS      = 300;
    localparam int TIMEOUT_NS       = 15_000_000;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [REG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [PIXEL_BITS-1:0]    pixel_value;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [GRAD_W-1:0] gradient;
    logic [ROW_W-1:0]         out_row;
    logic [COL_W-1:0]         out_col;
    logic                     last_of_image;

    int mismatches;
    int pending;
    int checked;
    int pixels;
    int writes;

    // Shared knobs: idle density for both sides, and the one-shot long hold.
    int gap_pct;
    bit long_hold;

    // Mirror of the raster position, so config changes land where intended.
    int eff_w;
    int eff_h;
    int pos_col;
    int pos_row;
    int sent_pixels;

    // Pixel count from which all idling stops; negative while not yet set.
    int tail_start;

    logic [PIXEL_BITS-1:0] extreme_image [12];

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    roberts_cross_gradient uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_value   (pixel_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gradient      (gradient),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_image (last_of_image)
    );

    gradient_checker grad_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .pixel_value       (pixel_value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .gradient          (gradient),
        .out_row           (out_row),
        .out_col           (out_col),
        .last_of_image     (last_of_image),
        .mismatch_count    (mismatches),
        .pending_count     (pending),
        .gradients_checked (checked),
        .pixels_seen       (pixels),
        .reg_writes        (writes)
    );

    // Offer one register transaction and hold it until accepted. Valid stays
    // high on return so writes can follow back to back; the caller
    // drops it after the last write of a batch.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_WIDTH:
            begin
                eff_w = int'(data[WCNT_W-1:0]);
                if (eff_w < 3) eff_w = 3;
                if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
            end
            REG_HEIGHT:
            begin
                eff_h = int'(data);
                if (eff_h < 3) eff_h = 3;
            end
            default: ;
        endcase
    endtask

    // Offer one pixel transaction, maybe after a short idle burst, and hold
    // it until accepted. Advance the raster mirror the way the block does.
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] v);
        if (tail_start >= 0 && sent_pixels >= tail_start)
            gap_pct = 0;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_pixels++;
        if (pos_col + 1 >= eff_w)
        begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= eff_h) ? 0 : pos_row + 1;
        end
        else
        begin
            pos_col++;
        end
    endtask

    // Drop valid and wait until every predicted gradient has come out, then
    // let the pipeline drain so border pixels in flight are done too.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // Mostly full-range noise, with a fair share of the rails and of small
    // values so large and tiny differences both show up.
    function automatic logic [PIXEL_BITS-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return PIXEL_BITS'($urandom_range(0, 15));
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    // Stream pixels until the raster is back at row 0, column 0. When asked,
    // stop partway, drain, and change one register mid-image: the direction,
    // the height (either way), or the width (never wider, so that no row
    // store entry is read before it has been written).
    task automatic run_image(input bit disturb);
        int cut;
        int n;
        cut = disturb ? $urandom_range(1, eff_w * eff_h - 1) : -1;
        n   = 0;
        do
        begin
            if (n == cut)
            begin
                settle();
                case ($urandom_range(0, 2))
                    0:       write_reg(REG_DIRECTION, CFG_DATA_W'($urandom));
                    1:       write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(0, eff_w)));
                    default: write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(0, 12)));
                endcase
                cfg_valid <= 1'b0;
            end
            send_pixel(random_pixel());
            n++;
        end
        while (pos_col != 0 || pos_row != 0);
    endtask

    // Receiver: idle bursts at the current density, plus one long hold-off
    // so the block backs up and stalls its input.
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("run timed out with %0d gradients still outstanding", pending);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int  base;
        bit  first;
        bit  quiet;

        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_DIRECTION;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        pixel_value <= '0;
        gap_pct     = 0;
        long_hold   = 1'b0;
        eff_w       = MAX_WIDTH;
        eff_h       = 4096;
        pos_col     = 0;
        pos_row     = 0;
        sent_pixels = 0;
        tail_start  = -1;

        // 4x3 image whose two interior gradients hit both rails under either
        // mask: +65535 on row 1 and -65535 on row 2.
        extreme_image = '{16'h0000, 16'hFFFF, 16'h0000,
                          16'h0000, 16'hFFFF, 16'h0000,
                          16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'h0000, 16'hFFFF};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Rail-to-rail differences, horizontal mask first.
        gap_pct = 20;
        write_reg(REG_DIRECTION, '0);
        write_reg(REG_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_HEIGHT, CFG_DATA_W'(4));
        write_reg(REG_SPARE, '1);
        cfg_valid <= 1'b0;
        foreach (extreme_image[k]) send_pixel(extreme_image[k]);
        settle();

        // Same image under the vertical mask; upper data bits are ignored.
        write_reg(REG_DIRECTION, '1);
        cfg_valid <= 1'b0;
        foreach (extreme_image[k]) send_pixel(extreme_image[k]);
        settle();

        // Sizes below the minimum clamp to 3x3: one interior pixel.
        write_reg(REG_WIDTH, '0);
        write_reg(REG_HEIGHT, CFG_DATA_W'(1));
        cfg_valid <= 1'b0;
        run_image(1'b0);
        settle();

        // Width beyond the line store clamps to the widest row. Leave that
        // row partway by shrinking the width, so the column counter beyond
        // the new limit must wrap to zero.
        write_reg(REG_WIDTH, '1);
        write_reg(REG_HEIGHT, CFG_DATA_W'(3));
        cfg_valid <= 1'b0;
        repeat (WIDE_PIXELS) send_pixel(random_pixel());
        settle();
        write_reg(REG_WIDTH, CFG_DATA_W'(6));
        cfg_valid <= 1'b0;
        run_image(1'b0);
        settle();

        // Tallest height, cut short mid-row: shrink both sizes so row and
        // column counters are past the new limits and must wrap to zero.
        write_reg(REG_WIDTH, CFG_DATA_W'(12));
        write_reg(REG_HEIGHT, '1);
        cfg_valid <= 1'b0;
        repeat (12 * 5 + 7) send_pixel(random_pixel());
        settle();
        write_reg(REG_WIDTH, CFG_DATA_W'(5));
        write_reg(REG_HEIGHT, CFG_DATA_W'(4));
        cfg_valid <= 1'b0;
        run_image(1'b0);
        run_image(1'b0);
        settle();

        // Random phases: new sizes and mask at each image boundary, now and
        // then a change in mid-image. The first phase holds the receiver off
        // for a long stretch while pixels keep coming. The tail runs with no
        // idling at all.
        base       = sent_pixels;
        first      = 1'b1;
        tail_start = base + RANDOM_PIXELS - QUIET_PIXELS;
        while (sent_pixels - base < RANDOM_PIXELS)
        begin
            quiet = (sent_pixels - base >= RANDOM_PIXELS - QUIET_PIXELS);
            if (first)
            begin
                gap_pct = 0;
                write_reg(REG_DIRECTION, CFG_DATA_W'($urandom));
                write_reg(REG_WIDTH, CFG_DATA_W'(32));
                write_reg(REG_HEIGHT, CFG_DATA_W'(10));
                long_hold = 1'b1;
                first     = 1'b0;
            end
            else
            begin
                if (quiet)
                begin
                    gap_pct = 0;
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       gap_pct = 0;
                        1:       gap_pct = 10;
                        2:       gap_pct = 30;
                        default: gap_pct = 50;
                    endcase
                end
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_DIRECTION, CFG_DATA_W'($urandom));
                if ($urandom_range(0, 3) != 0)
                begin
                    case ($urandom_range(0, 19))
                        0:       write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(0, 2)));
                        1, 2:    write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(11, 64)));
                        default: write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(3, 10)));
                    endcase
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    case ($urandom_range(0, 19))
                        0:       write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(0, 2)));
                        1, 2:    write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(9, 20)));
                        default: write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(3, 8)));
                    endcase
                end
            end
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 3))
                run_image(!quiet && $urandom_range(0, 3) == 0);
            settle();
        end

        $display("Streamed %0d pixels and checked %0d gradients over %0d register writes,",
                 pixels, checked, writes);
        $display("covering both masks, clamped and widest sizes, and mid-image size changes.");
        if (mismatches == 0 && pending == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("%0d mismatches, %0d gradients never arrived", mismatches, pending);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
